// ----- sv/c3r_pkg.sv -----
// Shared types, register codes and defaults for the 3x3 reflect-border convolution block.
package c3r_pkg;

  localparam int C3R_MAX_WIDTH = 2048;
  localparam int C3R_COEF_BITS = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_in;
  } c3r_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       row_end;
    logic       frame_end;
  } c3r_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } c3r_nst_t;

endpackage

// ----- sv/c3r_line_store.sv -----
// Two line memories holding the two previous image rows, with registered reads.
module c3r_line_store #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_older,
  input  logic [7:0]    wr_newer,
  output logic [7:0]    rd_older,
  output logic [7:0]    rd_newer
);
  import c3r_pkg::*;

  logic [7:0] older_mem [MAX_WIDTH];
  logic [7:0] newer_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
    rd_older <= older_mem[rd_addr];
    rd_newer <= newer_mem[rd_addr];
  end

endmodule

// ----- sv/c3r_norm.sv -----
// Serial 3x3 multiply-accumulate, then a bit-serial normalizing divide or a 0/255 clamp.
module c3r_norm #(
  parameter int COEF_BITS = 16,
  parameter int RW        = 3 * COEF_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [71:0]            pix,
  input  logic [2:0][RW-1:0]     coef,
  output c3r_pkg::c3r_nst_t      nst,
  output logic [7:0]             result
);
  import c3r_pkg::*;

  localparam int DW = COEF_BITS + 13;
  localparam int SW = COEF_BITS + 4;

  typedef enum logic [4:0] {
    N_IDLE = 5'b00001,
    N_MAC  = 5'b00010,
    N_CHK  = 5'b00100,
    N_DIV  = 5'b01000,
    N_DONE = 5'b10000
  } nstate_t;

  nstate_t                 state_r;
  logic [71:0]             pix_r;
  logic [1:0]              i_r, j_r;
  logic signed [DW-1:0]    acc_r;
  logic signed [SW-1:0]    sum_r;
  logic [DW-1:0]           rem_r, div_r;
  logic [2:0]              bcnt_r;
  logic [7:0]              q_r;

  logic [1:0]              rsel, csel;
  logic [3:0]              pidx;
  logic signed [COEF_BITS-1:0] k;
  logic signed [COEF_BITS+8:0] prod;
  logic signed [SW-1:0]    sum0;
  logic                    neg_d, neg_s;
  logic [DW-1:0]           ad, as_ext;
  logic                    ge;

  always_comb begin
    rsel   = 2'(2'd2 - i_r);
    csel   = 2'(2'd2 - j_r);
    pidx   = ({2'b00, i_r} * 4'd3) + {2'b00, j_r};
    k      = coef[rsel][csel*COEF_BITS +: COEF_BITS];
    prod   = $signed({1'b0, pix_r[pidx*8 +: 8]}) * k;
    sum0   = (sum_r == '0) ? SW'(1) : sum_r;
    neg_d  = acc_r[DW-1];
    neg_s  = sum0[SW-1];
    ad     = neg_d ? DW'(-acc_r) : DW'(acc_r);
    as_ext = neg_s ? DW'(unsigned'(-sum0)) : DW'(unsigned'(sum0));
    ge     = rem_r >= div_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            pix_r   <= pix;
            acc_r   <= '0;
            sum_r   <= '0;
            i_r     <= 2'd0;
            j_r     <= 2'd0;
            state_r <= N_MAC;
          end
        end
        N_MAC: begin
          acc_r <= acc_r + DW'(prod);
          sum_r <= sum_r + SW'(k);
          if (j_r == 2'd2) begin
            j_r <= 2'd0;
            i_r <= i_r + 2'd1;
            if (i_r == 2'd2) begin
              state_r <= N_CHK;
            end
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        N_CHK: begin
          if (acc_r == '0 || neg_d != neg_s) begin
            q_r     <= 8'd0;
            state_r <= N_DONE;
          end else if (ad >= (as_ext << 8)) begin
            q_r     <= 8'd255;
            state_r <= N_DONE;
          end else begin
            rem_r   <= ad;
            div_r   <= as_ext << 7;
            bcnt_r  <= 3'd7;
            q_r     <= 8'd0;
            state_r <= N_DIV;
          end
        end
        N_DIV: begin
          if (ge) begin
            rem_r <= rem_r - div_r;
          end
          q_r    <= {q_r[6:0], ge};
          div_r  <= div_r >> 1;
          bcnt_r <= bcnt_r - 3'd1;
          if (bcnt_r == 3'd0) begin
            state_r <= N_DONE;
          end
        end
        N_DONE: begin
          state_r <= N_IDLE;
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign nst.busy = (state_r != N_IDLE);
  assign nst.done = (state_r == N_DONE);
  assign result   = q_r;

endmodule

// ----- sv/conv3x3_reflect_normalized.sv -----
// Top level of the 3x3 reflect-border convolution with coefficient-sum normalization.
//
//   channel  direction  handshake        payload
//   in_      input      valid / stall    c3r_in_t  (cmd, pixel_in)
//   out_     output     valid / stall    c3r_out_t (pixel_out, row_end, frame_end)
//   cfg_     input      valid / ready    index, data
//
// A pixel transaction holds the input while it computes up to two results in the shared serial
// multiply-accumulate and divide unit; a drain transaction holds it for its three column reads
// and its one result. A zero or saturated quotient skips the eight divide steps.
// Reset clears counters, window registers and control; the line memories are not cleared.
// A stalled output holds its result; the next transaction is taken once all of its results
// have left the unit, while the last one may still wait in the output register.
module conv3x3_reflect_normalized #(
  parameter int MAX_WIDTH = c3r_pkg::C3R_MAX_WIDTH,
  parameter int COEF_BITS = c3r_pkg::C3R_COEF_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  c3r_pkg::c3r_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output c3r_pkg::c3r_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [c3r_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [3*COEF_BITS-1:0]            cfg_data
);
  import c3r_pkg::*;

  localparam int RW = 3 * COEF_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > 12) ? CW : 12;

  function automatic logic [RW-1:0] keep_mask();
    logic [RW-1:0] m;
    for (int b = 0; b < RW; b++) begin
      m[b] = (b < 64);
    end
    return m;
  endfunction

  localparam logic [RW-1:0] KEEP = keep_mask();

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRD   = 6'b000010,
    S_DRD   = 6'b000100,
    S_EMIT  = 6'b001000,
    S_NWAIT = 6'b010000,
    S_PUT   = 6'b100000
  } state_t;

  state_t              state_r;
  logic [2:0][RW-1:0]  coef_r;
  logic [11:0]         width_r;
  logic [12:0]         height_r;
  logic [AW-1:0]       col_r;
  logic [12:0]         row_r;
  logic                drain_r;
  logic [7:0]          pix_r;
  logic [23:0]         w0_r, w1_r, w2_r;
  logic                pend_a_r, pend_b_r, b_re_r, b_fe_r, cur_b_r;
  logic                c1_r, cge1_r, rge2_r, mode_drain_r, dlast_r;
  logic [AW-1:0]       dcol_r [3];
  logic [7:0]          dtop_r [3];
  logic [7:0]          dnew_r [3];
  logic [1:0]          dcnt_r;
  logic [7:0]          res_r;
  c3r_out_t            out_r;
  logic                out_valid_r;

  logic [WW-1:0]       wx;
  logic [CW-1:0]       w_eff;
  logic [12:0]         h_eff;
  logic [CW:0]         col_p1;
  logic                last;
  logic [CW-1:0]       colx, cc, col0, col2;
  logic                accept, out_load;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [7:0]          rd_older, rd_newer;
  logic [23:0]         src [3];
  logic [7:0]          pw [3][3];
  logic [71:0]         win;
  logic                nstart;
  c3r_nst_t            nst;
  logic [7:0]          nres;

  always_comb begin
    wx = WW'(width_r);
    if (wx == '0) begin
      wx = WW'(1);
    end else if (wx > WW'(MAX_WIDTH)) begin
      wx = WW'(MAX_WIDTH);
    end
    w_eff  = CW'(wx);
    h_eff  = (height_r == '0) ? 13'd1 : height_r;
    colx   = CW'(col_r);
    col_p1 = {1'b0, colx} + (CW+1)'(1);
    last   = col_p1 >= {1'b0, w_eff};
    cc     = (colx < w_eff) ? colx : CW'(w_eff - CW'(1));
    col0   = (cc == '0) ? cc : CW'(cc - CW'(1));
    col2   = ({1'b0, cc} + (CW+1)'(1) >= {1'b0, w_eff}) ? cc : CW'(cc + CW'(1));
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_PUT) && (!out_valid_r || !out_stall);
  assign nstart    = (state_r == S_EMIT) && (pend_a_r || pend_b_r);
  assign wr_en     = (state_r == S_PRD);

  always_comb begin
    rd_addr = col_r;
    if (state_r == S_IDLE && in_data.cmd == CMD_DRAIN) begin
      rd_addr = AW'(col0);
    end else if (state_r == S_DRD) begin
      rd_addr = (dcnt_r == 2'd0) ? dcol_r[1] : dcol_r[2];
    end
  end

  always_comb begin
    src[0] = rge2_r ? w0_r : w1_r;
    src[1] = w1_r;
    src[2] = w2_r;
    if (mode_drain_r) begin
      for (int i = 0; i < 3; i++) begin
        pw[0][i] = dtop_r[i];
        pw[1][i] = dnew_r[i];
        pw[2][i] = dnew_r[i];
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (pend_a_r) begin
          pw[i][0] = c1_r ? src[i][15:8] : src[i][23:16];
          pw[i][1] = src[i][15:8];
          pw[i][2] = src[i][7:0];
        end else begin
          pw[i][0] = cge1_r ? src[i][15:8] : src[i][7:0];
          pw[i][1] = src[i][7:0];
          pw[i][2] = src[i][7:0];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[(i*3+j)*8 +: 8] = pw[i][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= '0;
      coef_r[1] <= RW'(1) << COEF_BITS;
      coef_r[2] <= '0;
      width_r   <= 12'd640;
      height_r  <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COEF_TOP: coef_r[0] <= cfg_data & KEEP;
        REG_COEF_MID: coef_r[1] <= cfg_data & KEEP;
        REG_COEF_BOT: coef_r[2] <= cfg_data & KEEP;
        REG_WIDTH:    width_r   <= cfg_data[11:0];
        REG_HEIGHT:   height_r  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      drain_r      <= 1'b0;
      w0_r         <= '0;
      w1_r         <= '0;
      w2_r         <= '0;
      pend_a_r     <= 1'b0;
      pend_b_r     <= 1'b0;
      mode_drain_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pix_r <= in_data.pixel_in;
            if (in_data.cmd == CMD_PIXEL && !drain_r) begin
              state_r <= S_PRD;
            end else if (in_data.cmd == CMD_DRAIN && drain_r) begin
              dcol_r[0] <= AW'(col0);
              dcol_r[1] <= AW'(cc);
              dcol_r[2] <= AW'(col2);
              dlast_r   <= last;
              dcnt_r    <= 2'd0;
              state_r   <= S_DRD;
            end
          end
        end
        S_PRD: begin
          w0_r         <= {w0_r[15:0], rd_older};
          w1_r         <= {w1_r[15:0], rd_newer};
          w2_r         <= {w2_r[15:0], pix_r};
          pend_a_r     <= (row_r != '0) && (col_r != '0);
          pend_b_r     <= (row_r != '0) && last;
          b_re_r       <= 1'b1;
          b_fe_r       <= 1'b0;
          c1_r         <= (col_r == AW'(1));
          cge1_r       <= (col_r != '0);
          rge2_r       <= (row_r >= 13'd2);
          mode_drain_r <= 1'b0;
          if (last) begin
            col_r <= '0;
            row_r <= row_r + 13'd1;
            if ({1'b0, row_r} + 14'd1 >= {1'b0, h_eff}) begin
              drain_r <= 1'b1;
            end
          end else begin
            col_r <= col_r + AW'(1);
          end
          state_r <= S_EMIT;
        end
        S_DRD: begin
          dtop_r[dcnt_r] <= (row_r >= 13'd2) ? rd_older : rd_newer;
          dnew_r[dcnt_r] <= rd_newer;
          if (dcnt_r == 2'd2) begin
            pend_b_r     <= 1'b1;
            b_re_r       <= dlast_r;
            b_fe_r       <= dlast_r;
            mode_drain_r <= 1'b1;
            if (dlast_r) begin
              col_r   <= '0;
              row_r   <= '0;
              drain_r <= 1'b0;
            end else begin
              col_r <= col_r + AW'(1);
            end
            state_r <= S_EMIT;
          end else begin
            dcnt_r <= dcnt_r + 2'd1;
          end
        end
        S_EMIT: begin
          if (pend_a_r) begin
            pend_a_r <= 1'b0;
            cur_b_r  <= 1'b0;
            state_r  <= S_NWAIT;
          end else if (pend_b_r) begin
            pend_b_r <= 1'b0;
            cur_b_r  <= 1'b1;
            state_r  <= S_NWAIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_NWAIT: begin
          if (nst.done) begin
            res_r   <= nres;
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_load) begin
            state_r <= S_EMIT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.pixel_out <= res_r;
      out_r.row_end   <= cur_b_r && b_re_r;
      out_r.frame_end <= cur_b_r && b_fe_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  c3r_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (col_r),
    .wr_older (rd_newer),
    .wr_newer (pix_r),
    .rd_older (rd_older),
    .rd_newer (rd_newer)
  );

  c3r_norm #(
    .COEF_BITS (COEF_BITS),
    .RW        (RW)
  ) u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (nstart),
    .pix    (win),
    .coef   (coef_r),
    .nst    (nst),
    .result (nres)
  );

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    nstart |-> !nst.busy) else $error("normalizer started while busy");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    nst.done |-> state_r == S_NWAIT) else $error("normalizer result not awaited");
  a_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !pend_a_r && !pend_b_r) else $error("transaction taken with results pending");
`endif

endmodule

// ----- dv/conv3x3_reflect_checker.sv -----
// Checker that predicts the filtered pixel stream and compares it with the block's results.
module conv3x3_reflect_checker
  import c3r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  c3r_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  c3r_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic [47:0] coef_q [3];
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [7:0]  older_mem [C3R_MAX_WIDTH];
  logic [7:0]  newer_mem [C3R_MAX_WIDTH];
  logic [23:0] win [3];
  int unsigned col_cnt;
  int unsigned row_cnt;
  bit          draining;
  c3r_out_t    expected_px_q [$];

  function automatic longint coef(int r, int c);
    return longint'($signed(coef_q[r][c*16 +: 16]));
  endfunction

  function automatic c3r_out_t filter_px(logic [2:0][2:0][7:0] p, bit re, bit fe);
    longint dot;
    longint sum;
    longint k;
    longint q;
    c3r_out_t res;
    dot = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        k = coef(2 - i, 2 - j);
        dot += longint'(p[i][j]) * k;
        sum += k;
      end
    end
    if (sum == 0) sum = 1;
    q = dot / sum;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    res.pixel_out = q[7:0];
    res.row_end = re;
    res.frame_end = fe;
    return res;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > C3R_MAX_WIDTH) return C3R_MAX_WIDTH;
    return width_reg;
  endfunction

  task automatic predict_pixel(logic [7:0] pix);
    int unsigned w;
    int unsigned c;
    int unsigned idx;
    logic [7:0] o;
    logic [7:0] nw;
    bit last;
    logic [23:0] src [3];
    logic [2:0][2:0][7:0] p;
    w = eff_width();
    c = col_cnt;
    if (draining) return;
    idx = (c < C3R_MAX_WIDTH) ? c : C3R_MAX_WIDTH - 1;
    o = older_mem[idx];
    nw = newer_mem[idx];
    win[0] = {win[0][15:0], o};
    win[1] = {win[1][15:0], nw};
    win[2] = {win[2][15:0], pix};
    older_mem[idx] = nw;
    newer_mem[idx] = pix;
    last = (c + 1 >= w);
    if (row_cnt >= 1) begin
      src[0] = (row_cnt >= 2) ? win[0] : win[1];
      src[1] = win[1];
      src[2] = win[2];
      if (c >= 1) begin
        for (int i = 0; i < 3; i++) begin
          p[i][0] = (c == 1) ? src[i][15:8] : src[i][23:16];
          p[i][1] = src[i][15:8];
          p[i][2] = src[i][7:0];
        end
        expected_px_q.push_back(filter_px(p, 1'b0, 1'b0));
      end
      if (last) begin
        for (int i = 0; i < 3; i++) begin
          p[i][0] = (c >= 1) ? src[i][15:8] : src[i][7:0];
          p[i][1] = src[i][7:0];
          p[i][2] = src[i][7:0];
        end
        expected_px_q.push_back(filter_px(p, 1'b1, 1'b0));
      end
    end
    if (last) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= ((height_reg == 0) ? 1 : height_reg)) draining = 1'b1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic predict_drain();
    int unsigned w;
    int unsigned c;
    int unsigned cc;
    int unsigned k;
    int unsigned cols [3];
    bit last;
    logic [2:0][2:0][7:0] p;
    if (!draining) return;
    w = eff_width();
    c = col_cnt;
    cc = (c < w) ? c : w - 1;
    last = (c + 1 >= w);
    cols[0] = (cc == 0) ? 0 : cc - 1;
    cols[1] = cc;
    cols[2] = (cc + 1 >= w) ? cc : cc + 1;
    for (int i = 0; i < 3; i++) begin
      k = (cols[i] < C3R_MAX_WIDTH) ? cols[i] : C3R_MAX_WIDTH - 1;
      p[0][i] = (row_cnt >= 2) ? older_mem[k] : newer_mem[k];
      p[1][i] = newer_mem[k];
      p[2][i] = newer_mem[k];
    end
    expected_px_q.push_back(filter_px(p, last, last));
    if (last) begin
      col_cnt = 0;
      row_cnt = 0;
      draining = 1'b0;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  always @(posedge clk) begin
    c3r_out_t exp_px;
    if (!rst_n) begin
      coef_q[0] = '0;
      coef_q[1] = 48'h0000_0001_0000;
      coef_q[2] = '0;
      width_reg = 12'd640;
      height_reg = 13'd480;
      for (int i = 0; i < C3R_MAX_WIDTH; i++) begin
        older_mem[i] = '0;
        newer_mem[i] = '0;
      end
      for (int i = 0; i < 3; i++) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      draining = 1'b0;
      expected_px_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_px_q.size() == 0) begin
          if (fail_count < 10)
            $display("Unexpected result transaction: %p", out_data);
          fail_count++;
        end else begin
          exp_px = expected_px_q.pop_front();
          if (exp_px !== out_data) begin
            if (fail_count < 10)
              $display("Result mismatch: expected pixel %0d row_end %0b frame_end %0b, got pixel %0d row_end %0b frame_end %0b",
                       exp_px.pixel_out, exp_px.row_end, exp_px.frame_end,
                       out_data.pixel_out, out_data.row_end, out_data.frame_end);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CMD_PIXEL) predict_pixel(in_data.pixel_in);
        else predict_drain();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COEF_TOP: coef_q[0] = cfg_data;
          REG_COEF_MID: coef_q[1] = cfg_data;
          REG_COEF_BOT: coef_q[2] = cfg_data;
          REG_WIDTH:    width_reg = cfg_data[11:0];
          REG_HEIGHT:   height_reg = cfg_data[12:0];
          default: ;
        endcase
      end
    end
    pending <= expected_px_q.size();
  end

endmodule

// ----- dv/conv3x3_reflect_normalized_tb.sv -----
// Top of the testbench: drives pixel frames, drain transactions and kernel settings, gives the verdict.
module conv3x3_reflect_normalized_tb;
  import c3r_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  c3r_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  c3r_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [47:0]          cfg_data = '0;
  int                   fail_count;
  int                   pending;
  int                   send_pct = 0;
  int                   stall_pct = 0;
  int                   sent_items = 0;
  int                   cycles = 0;

  conv3x3_reflect_normalized DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  conv3x3_reflect_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] pack_row(int a, int b, int c);
    logic [15:0] fa;
    logic [15:0] fb;
    logic [15:0] fc;
    fa = a[15:0];
    fb = b[15:0];
    fc = c[15:0];
    return {fc, fb, fa};
  endfunction

  function automatic logic [47:0] rand_row();
    case ($urandom_range(2))
      0: return 48'({$urandom(), $urandom()});
      1: return pack_row($urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4);
      default: return pack_row($urandom_range(3), $urandom_range(3), $urandom_range(3));
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic set_phase(int mode);
    send_pct = (mode == 1) ? 57 : (mode == 3) ? 36 : 0;
    stall_pct = (mode == 2) ? 57 : (mode == 3) ? 36 : 0;
  endtask

  task automatic send_item(logic cmd, logic [7:0] pix);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: cmd, pixel_in: pix};
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sent_items++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic run_frame(logic [47:0] k0, logic [47:0] k1, logic [47:0] k2,
                           int wv, int hv, bit noisy);
    logic [47:0] d;
    int w;
    int h;
    w = (wv == 0) ? 1 : (wv > C3R_MAX_WIDTH) ? C3R_MAX_WIDTH : wv;
    h = (hv == 0) ? 1 : hv;
    write_reg(REG_COEF_TOP, k0);
    write_reg(REG_COEF_MID, k1);
    write_reg(REG_COEF_BOT, k2);
    d = 48'({$urandom(), $urandom()});
    d[11:0] = wv[11:0];
    write_reg(REG_WIDTH, d);
    d = 48'({$urandom(), $urandom()});
    d[12:0] = hv[12:0];
    write_reg(REG_HEIGHT, d);
    cfg_valid <= 1'b0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (noisy && $urandom_range(19) == 0)
          send_item(CMD_DRAIN, 8'($urandom_range(255)));
        send_item(CMD_PIXEL, pick_pixel());
      end
    end
    if (noisy && $urandom_range(3) == 0) send_item(CMD_PIXEL, 8'($urandom_range(255)));
    for (int c = 0; c < w; c++) send_item(CMD_DRAIN, 8'($urandom_range(255)));
    wait_idle();
  endtask

  initial begin
    int frame_idx;
    int wv;
    int hv;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_phase(0);
    run_frame(48'h0, pack_row(0, 1, 0), 48'h0, 4, 3, 1'b0);
    run_frame(pack_row(1, 1, 1), pack_row(1, 1, 1), pack_row(1, 1, 1), 0, 0, 1'b1);
    run_frame(pack_row(0, -1, 0), pack_row(-1, 4, -1), pack_row(0, -1, 0), 3, 2, 1'b1);
    run_frame(pack_row(-1, -1, -1), pack_row(-1, -2, -1), pack_row(-1, -1, -1), 5, 2, 1'b1);
    run_frame(pack_row(32767, -32768, 32767), pack_row(-32768, 32767, -32768),
              pack_row(1, 2, -3), 2, 4, 1'b0);
    frame_idx = 0;
    while (sent_items < 830) begin
      set_phase(frame_idx % 4);
      wv = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
      hv = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 8);
      run_frame(rand_row(), rand_row(), rand_row(), wv, hv, 1'b1);
      frame_idx++;
    end
    set_phase(0);
    run_frame(rand_row(), rand_row(), rand_row(), 40, 1, 1'b0);
    run_frame(pack_row(1, 2, 1), pack_row(2, 4, 2), pack_row(1, 2, 1), 1, 40, 1'b0);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/c3r_pkg.sv
sv/c3r_line_store.sv
sv/c3r_norm.sv
sv/conv3x3_reflect_normalized.sv
dv/conv3x3_reflect_checker.sv
dv/conv3x3_reflect_normalized_tb.sv
